>>> rtl/core/imu_ca_pkg.sv
// imu_ca_pkg: shared types, constants and tables of the IMU attitude estimator.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
package imu_ca_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int DIV_BITS     = 26;
   localparam int CNT_W        = 5;

   localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_RUN - 1);
   localparam logic [CNT_W-1:0] CORDIC_LIM = CNT_W'(CORDIC_RUN);

   localparam logic [2:0] MUL_INC_X   = 3'd0;
   localparam logic [2:0] MUL_INC_Y   = 3'd1;
   localparam logic [2:0] MUL_INC_Z   = 3'd2;
   localparam logic [2:0] MUL_ROLL_G  = 3'd3;
   localparam logic [2:0] MUL_ROLL_A  = 3'd4;
   localparam logic [2:0] MUL_PITCH_G = 3'd5;
   localparam logic [2:0] MUL_PITCH_A = 3'd6;
   localparam logic [2:0] MUL_DRAIN   = 3'd7;

   localparam logic [2:0] REG_ACCEL_RANGE = 3'd0;
   localparam logic [2:0] REG_GYRO_RANGE  = 3'd1;
   localparam logic [2:0] REG_BLEND       = 3'd2;
   localparam logic [2:0] REG_STEP        = 3'd3;
   localparam logic [2:0] REG_OFF_GX      = 3'd4;
   localparam logic [2:0] REG_OFF_GY      = 3'd5;
   localparam logic [2:0] REG_OFF_GZ      = 3'd6;

   localparam logic signed [26:0] ANGLE_180 = 27'sd11796480;
   localparam logic [15:0] WEIGHT_ONE = 16'h8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ITER,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]         accel_range;
      logic [1:0]         gyro_range;
      logic [15:0]        blend_weight;
      logic [23:0]        step_time;
      logic signed [19:0] offset_gx;
      logic signed [19:0] offset_gy;
      logic signed [19:0] offset_gz;
   } cfg_type;

   typedef struct packed {
      logic             capture;
      logic             load;
      logic             iter;
      logic [CNT_W-1:0] iter_idx;
      logic             mul_go;
      logic [2:0]       mul_step;
      logic             publish;
   } cmd_type;

   function automatic logic [21:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic [21:0] r;
      case (idx)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117304;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   // ceil(2^37 / divisor); exact floor quotient for dividends below 2^26
   function automatic logic [29:0] gyro_recip(input logic [1:0] rng);
      logic [29:0] r;
      case (rng)
         2'd0: r = 30'd104915232;
         2'd1: r = 30'd209830464;
         2'd2: r = 30'd419021200;
         default: r = 30'd838042400;
      endcase
      return r;
   endfunction

   function automatic logic [9:0] gyro_half(input logic [1:0] rng);
      logic [9:0] r;
      case (rng)
         2'd0: r = 10'd655;
         2'd1: r = 10'd327;
         2'd2: r = 10'd164;
         default: r = 10'd82;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/imu_ca_csr.sv
// imu_ca_csr: APB-style configuration registers of the attitude estimator.
// Depends on imu_ca_pkg.
`timescale 1ns / 1ps
module imu_ca_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output imu_ca_pkg::cfg_type cfg
);

   imu_ca_pkg::cfg_type cfg_ff;
   logic                wr;
   logic [2:0]          idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[4:2];
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_range  <= 2'd1;
         cfg_ff.gyro_range   <= 2'd1;
         cfg_ff.blend_weight <= 16'd32113;
         cfg_ff.step_time    <= 24'd16777;
         cfg_ff.offset_gx    <= '0;
         cfg_ff.offset_gy    <= '0;
         cfg_ff.offset_gz    <= '0;
      end else if (wr) begin
         case (idx)
            imu_ca_pkg::REG_ACCEL_RANGE: cfg_ff.accel_range  <= pwdata[1:0];
            imu_ca_pkg::REG_GYRO_RANGE:  cfg_ff.gyro_range   <= pwdata[1:0];
            imu_ca_pkg::REG_BLEND:       cfg_ff.blend_weight <= pwdata[15:0];
            imu_ca_pkg::REG_STEP:        cfg_ff.step_time    <= pwdata[23:0];
            imu_ca_pkg::REG_OFF_GX:      cfg_ff.offset_gx    <= $signed(pwdata[19:0]);
            imu_ca_pkg::REG_OFF_GY:      cfg_ff.offset_gy    <= $signed(pwdata[19:0]);
            imu_ca_pkg::REG_OFF_GZ:      cfg_ff.offset_gz    <= $signed(pwdata[19:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         imu_ca_pkg::REG_ACCEL_RANGE: prdata = {30'd0, cfg_ff.accel_range};
         imu_ca_pkg::REG_GYRO_RANGE:  prdata = {30'd0, cfg_ff.gyro_range};
         imu_ca_pkg::REG_BLEND:       prdata = {16'd0, cfg_ff.blend_weight};
         imu_ca_pkg::REG_STEP:        prdata = {8'd0, cfg_ff.step_time};
         imu_ca_pkg::REG_OFF_GX:      prdata = {{12{cfg_ff.offset_gx[19]}}, cfg_ff.offset_gx};
         imu_ca_pkg::REG_OFF_GY:      prdata = {{12{cfg_ff.offset_gy[19]}}, cfg_ff.offset_gy};
         imu_ca_pkg::REG_OFF_GZ:      prdata = {{12{cfg_ff.offset_gz[19]}}, cfg_ff.offset_gz};
         default:                     prdata = 32'd0;
      endcase
   end

endmodule

>>> rtl/core/imu_ca_ctrl.sv
// imu_ca_ctrl: sequencer of the attitude estimator; drives datapath commands
// and both handshakes. Depends on imu_ca_pkg.
`timescale 1ns / 1ps
module imu_ca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output imu_ca_pkg::cmd_type cmd
);

   imu_ca_pkg::state_type          state_ff, state_in;
   logic [imu_ca_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != imu_ca_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         imu_ca_pkg::ST_IDLE: begin
            if (req_valid) state_in = imu_ca_pkg::ST_LOAD;
         end
         imu_ca_pkg::ST_LOAD: begin
            state_in = imu_ca_pkg::ST_ITER;
            cnt_in   = '0;
         end
         imu_ca_pkg::ST_ITER: begin
            if (cnt_ff == imu_ca_pkg::ITER_LAST) begin
               state_in = imu_ca_pkg::ST_MUL;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         imu_ca_pkg::ST_MUL: begin
            if (cnt_ff[2:0] == imu_ca_pkg::MUL_DRAIN) begin
               state_in = imu_ca_pkg::ST_FINISH;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         imu_ca_pkg::ST_FINISH: begin
            if (out_free) state_in = imu_ca_pkg::ST_IDLE;
         end
         default: state_in = imu_ca_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.iter_idx = cnt_ff;
      cmd.mul_step = cnt_ff[2:0];
      case (state_ff)
         imu_ca_pkg::ST_IDLE:   cmd.capture = req_valid;
         imu_ca_pkg::ST_LOAD:   cmd.load    = 1'b1;
         imu_ca_pkg::ST_ITER:   cmd.iter    = 1'b1;
         imu_ca_pkg::ST_MUL:    cmd.mul_go  = (cnt_ff[2:0] != imu_ca_pkg::MUL_DRAIN);
         imu_ca_pkg::ST_FINISH: cmd.publish = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish)               rsp_valid_in = 1'b1;
      else if (rsp_valid_ff & ~rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imu_ca_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/imu_ca_dpath.sv
// imu_ca_dpath: scaling, reciprocal-multiply gyro scaling, two CORDIC lanes, the
// shared multiplier and the filter state. Depends on imu_ca_pkg.
`timescale 1ns / 1ps
module imu_ca_dpath (
   input  logic                clock,
   input  logic                reset,
   input  imu_ca_pkg::cmd_type cmd,
   input  imu_ca_pkg::cfg_type cfg,
   input  logic signed [15:0]  raw_ax,
   input  logic signed [15:0]  raw_ay,
   input  logic signed [15:0]  raw_az,
   input  logic signed [15:0]  raw_gx,
   input  logic signed [15:0]  raw_gy,
   input  logic signed [15:0]  raw_gz,
   output logic signed [31:0]  roll_deg,
   output logic signed [31:0]  pitch_deg,
   output logic signed [31:0]  yaw_deg,
   output logic signed [18:0]  accel_x_g,
   output logic signed [18:0]  accel_y_g,
   output logic signed [18:0]  accel_z_g,
   output logic signed [18:0]  rate_x_dps,
   output logic signed [18:0]  rate_y_dps,
   output logic signed [18:0]  rate_z_dps
);

   localparam int DB = imu_ca_pkg::DIV_BITS;

   logic signed [15:0] rawa_ff [3];
   logic signed [15:0] rawg_ff [3];
   logic signed [18:0] acc_ff  [3];
   logic signed [18:0] acc_in  [3];
   logic signed [19:0] offs    [3];

   logic [DB-1:0]      dvd_ff [3];
   logic [DB-1:0]      dvd_ld [3];
   logic [17:0]        quo_ff [3];
   logic               neg_ff [3];
   logic               neg_ld [3];
   logic signed [18:0] rate   [3];
   logic [DB-1:0]      dvd_sel;
   logic [29:0]        recip;
   logic [55:0]        qprod;

   logic signed [29:0] cx_ff [2];
   logic signed [29:0] cy_ff [2];
   logic signed [26:0] cz_ff [2];
   logic               zero_ff [2];
   logic signed [29:0] cx_in [2];
   logic signed [29:0] cy_in [2];
   logic signed [26:0] cz_in [2];
   logic signed [29:0] cx_ld [2];
   logic signed [29:0] cy_ld [2];
   logic signed [26:0] cz_ld [2];
   logic               zero_ld [2];
   logic signed [26:0] ang [2];

   logic signed [29:0] inc_ff [3];
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [57:0] prod_ff, accum_ff;
   logic [2:0]         pstep_ff;
   logic               pvld_ff;
   logic signed [32:0] op_a;
   logic signed [24:0] op_b;
   logic [15:0]        tau, ntau;
   logic signed [57:0] inc_full, blend_full;
   logic signed [42:0] blend_sh;
   logic signed [31:0] blend_sat;

   logic signed [31:0] out_roll_ff, out_pitch_ff, out_yaw_ff;
   logic signed [18:0] out_acc_ff [3];
   logic signed [18:0] out_rate_ff [3];

   assign offs[0] = cfg.offset_gx;
   assign offs[1] = cfg.offset_gy;
   assign offs[2] = cfg.offset_gz;

   // scaling and quotient set-up
   always_comb begin
      logic signed [20:0] gv;
      logic signed [26:0] n40;
      logic signed [26:0] mag;
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = $signed({{3{rawa_ff[k][15]}}, rawa_ff[k]}) <<< cfg.accel_range;
         gv  = $signed({rawg_ff[k][15], rawg_ff[k], 4'd0}) - $signed({offs[k][19], offs[k]});
         n40 = ($signed({{6{gv[20]}}, gv}) <<< 5) + ($signed({{6{gv[20]}}, gv}) <<< 3);
         neg_ld[k] = n40[26];
         mag = n40[26] ? -n40 : n40;
         dvd_ld[k] = mag[DB-1:0] + {16'd0, imu_ca_pkg::gyro_half(cfg.gyro_range)};
      end
   end

   // one gyro lane per cycle over the first three CORDIC steps
   always_comb begin
      case (cmd.iter_idx[1:0])
         2'd0:    dvd_sel = dvd_ff[0];
         2'd1:    dvd_sel = dvd_ff[1];
         default: dvd_sel = dvd_ff[2];
      endcase
   end

   assign recip = imu_ca_pkg::gyro_recip(cfg.gyro_range);
   assign qprod = 56'(dvd_sel) * 56'(recip);

   always_comb begin
      logic [26:0] q;
      logic signed [26:0] sq;
      for (int k = 0; k < 3; k++) begin
         q  = {9'd0, quo_ff[k]};
         sq = neg_ff[k] ? -$signed(q) : $signed(q);
         if (sq > 27'sd262143)       rate[k] = 19'sd262143;
         else if (sq < -27'sd262144) rate[k] = -19'sd262144;
         else                        rate[k] = sq[18:0];
      end
   end

   // CORDIC lanes: roll from (ax, az), pitch from (ay, az)
   always_comb begin
      logic signed [29:0] x0, y0, xs, ys;
      logic signed [26:0] at;
      for (int j = 0; j < 2; j++) begin
         x0 = $signed({{3{acc_in[2][18]}}, acc_in[2], 8'd0});
         y0 = $signed({{3{acc_in[j][18]}}, acc_in[j], 8'd0});
         zero_ld[j] = (acc_in[2] == 19'sd0) && (acc_in[j] == 19'sd0);
         if (x0 < 0) begin
            cx_ld[j] = -x0;
            cy_ld[j] = -y0;
            cz_ld[j] = (y0 >= 0) ? imu_ca_pkg::ANGLE_180 : -imu_ca_pkg::ANGLE_180;
         end else begin
            cx_ld[j] = x0;
            cy_ld[j] = y0;
            cz_ld[j] = '0;
         end
         xs = cx_ff[j] >>> cmd.iter_idx;
         ys = cy_ff[j] >>> cmd.iter_idx;
         at = $signed({5'd0, imu_ca_pkg::atan_entry(cmd.iter_idx)});
         if (cy_ff[j] >= 0) begin
            cx_in[j] = cx_ff[j] + ys;
            cy_in[j] = cy_ff[j] - xs;
            cz_in[j] = cz_ff[j] + at;
         end else begin
            cx_in[j] = cx_ff[j] - ys;
            cy_in[j] = cy_ff[j] + xs;
            cz_in[j] = cz_ff[j] - at;
         end
         ang[j] = zero_ff[j] ? 27'sd0 : cz_ff[j];
      end
   end

   // shared multiplier operands
   assign tau  = (cfg.blend_weight > imu_ca_pkg::WEIGHT_ONE) ? imu_ca_pkg::WEIGHT_ONE
                                                             : cfg.blend_weight;
   assign ntau = imu_ca_pkg::WEIGHT_ONE - tau;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_step)
         imu_ca_pkg::MUL_INC_X: begin
            op_a = 33'(rate[0]);
            op_b = $signed({1'b0, cfg.step_time});
         end
         imu_ca_pkg::MUL_INC_Y: begin
            op_a = 33'(rate[1]);
            op_b = $signed({1'b0, cfg.step_time});
         end
         imu_ca_pkg::MUL_INC_Z: begin
            op_a = 33'(rate[2]);
            op_b = $signed({1'b0, cfg.step_time});
         end
         imu_ca_pkg::MUL_ROLL_G: begin
            op_a = 33'(roll_ff) - 33'(inc_ff[1]);
            op_b = $signed({9'd0, tau});
         end
         imu_ca_pkg::MUL_ROLL_A: begin
            op_a = 33'(ang[0]);
            op_b = $signed({9'd0, ntau});
         end
         imu_ca_pkg::MUL_PITCH_G: begin
            op_a = 33'(pitch_ff) + 33'(inc_ff[0]);
            op_b = $signed({9'd0, tau});
         end
         imu_ca_pkg::MUL_PITCH_A: begin
            op_a = 33'(ang[1]);
            op_b = $signed({9'd0, ntau});
         end
         default: ;
      endcase
   end

   assign inc_full   = (prod_ff + 58'sd8192) >>> 14;
   assign blend_full = (prod_ff + accum_ff + 58'sd16384) >>> 15;
   assign blend_sh   = blend_full[42:0];
   always_comb begin
      if (blend_sh > 43'sd2147483647)       blend_sat = 32'sh7fffffff;
      else if (blend_sh < -43'sd2147483648) blend_sat = 32'sh80000000;
      else                                  blend_sat = blend_sh[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rawa_ff[0] <= raw_ax;
         rawa_ff[1] <= raw_ay;
         rawa_ff[2] <= raw_az;
         rawg_ff[0] <= raw_gx;
         rawg_ff[1] <= raw_gy;
         rawg_ff[2] <= raw_gz;
      end
      for (int k = 0; k < 3; k++) begin
         if (cmd.load) begin
            acc_ff[k] <= acc_in[k];
            dvd_ff[k] <= dvd_ld[k];
            neg_ff[k] <= neg_ld[k];
         end else if (cmd.iter && (int'(cmd.iter_idx) == k)) begin
            quo_ff[k] <= qprod[54:37];
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (cmd.load) begin
            cx_ff[j]   <= cx_ld[j];
            cy_ff[j]   <= cy_ld[j];
            cz_ff[j]   <= cz_ld[j];
            zero_ff[j] <= zero_ld[j];
         end else if (cmd.iter && (cmd.iter_idx < imu_ca_pkg::CORDIC_LIM)) begin
            cx_ff[j] <= cx_in[j];
            cy_ff[j] <= cy_in[j];
            cz_ff[j] <= cz_in[j];
         end
      end
      prod_ff  <= op_a * op_b;
      pstep_ff <= cmd.mul_step;
      if (pvld_ff) begin
         case (pstep_ff)
            imu_ca_pkg::MUL_INC_X:   inc_ff[0] <= inc_full[29:0];
            imu_ca_pkg::MUL_INC_Y:   inc_ff[1] <= inc_full[29:0];
            imu_ca_pkg::MUL_INC_Z:   inc_ff[2] <= inc_full[29:0];
            imu_ca_pkg::MUL_ROLL_G:  accum_ff  <= prod_ff;
            imu_ca_pkg::MUL_PITCH_G: accum_ff  <= prod_ff;
            default: ;
         endcase
      end
      if (cmd.publish) begin
         out_roll_ff  <= roll_ff;
         out_pitch_ff <= pitch_ff;
         out_yaw_ff   <= yaw_ff;
         for (int k = 0; k < 3; k++) begin
            out_acc_ff[k]  <= acc_ff[k];
            out_rate_ff[k] <= rate[k];
         end
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff  <= 1'b0;
         roll_ff  <= '0;
         pitch_ff <= '0;
         yaw_ff   <= '0;
      end else begin
         pvld_ff <= cmd.mul_go;
         if (pvld_ff) begin
            case (pstep_ff)
               imu_ca_pkg::MUL_INC_Z:   yaw_ff   <= yaw_ff + inc_full[31:0];
               imu_ca_pkg::MUL_ROLL_A:  roll_ff  <= blend_sat;
               imu_ca_pkg::MUL_PITCH_A: pitch_ff <= blend_sat;
               default: ;
            endcase
         end
      end
   end

   assign roll_deg   = out_roll_ff;
   assign pitch_deg  = out_pitch_ff;
   assign yaw_deg    = out_yaw_ff;
   assign accel_x_g  = out_acc_ff[0];
   assign accel_y_g  = out_acc_ff[1];
   assign accel_z_g  = out_acc_ff[2];
   assign rate_x_dps = out_rate_ff[0];
   assign rate_y_dps = out_rate_ff[1];
   assign rate_z_dps = out_rate_ff[2];

endmodule

>>> rtl/core/imu_complementary_attitude.sv
// imu_complementary_attitude: six-axis IMU complementary-filter attitude estimator.
// Steps from the accepted req beat to rsp_valid: load, 16 CORDIC steps whose first
// three also form the gyro rates, 8 shared-multiplier steps, publish (held while
// rsp_stall holds the last result); req_stall stays high until publish.
// Reset (synchronous): angles cleared, registers to defaults, no beat pending.
`timescale 1ns / 1ps
module imu_complementary_attitude (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_raw_ax,
   input  logic signed [15:0] req_raw_ay,
   input  logic signed [15:0] req_raw_az,
   input  logic signed [15:0] req_raw_gx,
   input  logic signed [15:0] req_raw_gy,
   input  logic signed [15:0] req_raw_gz,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_roll_deg,
   output logic signed [31:0] rsp_pitch_deg,
   output logic signed [31:0] rsp_yaw_deg,
   output logic signed [18:0] rsp_accel_x_g,
   output logic signed [18:0] rsp_accel_y_g,
   output logic signed [18:0] rsp_accel_z_g,
   output logic signed [18:0] rsp_rate_x_dps,
   output logic signed [18:0] rsp_rate_y_dps,
   output logic signed [18:0] rsp_rate_z_dps,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   imu_ca_pkg::cfg_type cfg;
   imu_ca_pkg::cmd_type cmd;

   imu_ca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   imu_ca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   imu_ca_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .raw_ax     (req_raw_ax),
      .raw_ay     (req_raw_ay),
      .raw_az     (req_raw_az),
      .raw_gx     (req_raw_gx),
      .raw_gy     (req_raw_gy),
      .raw_gz     (req_raw_gz),
      .roll_deg   (rsp_roll_deg),
      .pitch_deg  (rsp_pitch_deg),
      .yaw_deg    (rsp_yaw_deg),
      .accel_x_g  (rsp_accel_x_g),
      .accel_y_g  (rsp_accel_y_g),
      .accel_z_g  (rsp_accel_z_g),
      .rate_x_dps (rsp_rate_x_dps),
      .rate_y_dps (rsp_rate_y_dps),
      .rate_z_dps (rsp_rate_z_dps)
   );

endmodule

>>> sim/tb_imu_complementary_attitude.sv
// tb_imu_complementary_attitude: self-checking bench for the IMU attitude estimator.
// Directed table then random beats under random stalls, checked against an in-bench
// predictor of the filter; depends on imu_ca_pkg and imu_complementary_attitude.
`timescale 1ns / 1ps
module tb_imu_complementary_attitude;

   typedef struct packed {
      logic signed [31:0] roll;
      logic signed [31:0] pitch;
      logic signed [31:0] yaw;
      logic signed [18:0] ax;
      logic signed [18:0] ay;
      logic signed [18:0] az;
      logic signed [18:0] rx;
      logic signed [18:0] ry;
      logic signed [18:0] rz;
   } attitude_type;

   typedef struct {
      logic signed [15:0] s[6];
      bit                 typed;
   } sample_row_type;

   logic               clock, reset;
   logic               req_valid, req_stall;
   logic signed [15:0] req_raw_ax, req_raw_ay, req_raw_az;
   logic signed [15:0] req_raw_gx, req_raw_gy, req_raw_gz;
   logic               rsp_valid, rsp_stall;
   logic signed [31:0] rsp_roll_deg, rsp_pitch_deg, rsp_yaw_deg;
   logic signed [18:0] rsp_accel_x_g, rsp_accel_y_g, rsp_accel_z_g;
   logic signed [18:0] rsp_rate_x_dps, rsp_rate_y_dps, rsp_rate_z_dps;
   logic               psel, penable, pwrite, pready;
   logic [4:0]         paddr;
   logic [31:0]        pwdata, prdata;

   imu_complementary_attitude dut (.*);

   // predictor copy of registers and filter state
   int unsigned  m_accel_rng, m_gyro_rng, m_weight, m_step;
   longint       m_off[3];
   longint       m_roll, m_pitch;
   logic [31:0]  m_yaw;

   attitude_type expected_q[$];
   int           errors;
   bit           hold_long;
   bit           typed_next;
   attitude_type typed_val;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("imu_complementary_attitude: mismatch");
      $finish;
   end

   function automatic longint atan_tab(input int i);
      longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
      return t[i];
   endfunction

   function automatic longint cordic_angle(input longint y_in, input longint x_in);
      longint x, y, z, xs, ys;
      x = x_in * 256;
      y = y_in * 256;
      z = 0;
      if (x_in == 0 && y_in == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 11796480 : -11796480;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < imu_ca_pkg::CORDIC_RUN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += atan_tab(i);
         end else begin
            x = x - ys; y = y + xs; z -= atan_tab(i);
         end
      end
      return z;
   endfunction

   function automatic longint sat_to(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic attitude_type advance_attitude(input logic signed [15:0] s[6]);
      longint acc[3], rate[3], inc[3];
      longint n, a, q, d, tau, ang_r, ang_p, v;
      attitude_type r;
      case (m_gyro_rng)
         0: d = 1310;
         1: d = 655;
         2: d = 328;
         default: d = 164;
      endcase
      for (int k = 0; k < 3; k++) begin
         acc[k] = longint'(s[k]) * (longint'(1) << m_accel_rng);
         n = (longint'(s[3+k]) * 16 - m_off[k]) * 40;
         a = (n < 0) ? -n : n;
         q = (a + d / 2) / d;
         rate[k] = sat_to((n < 0) ? -q : q, -262144, 262143);
         inc[k] = (rate[k] * longint'(m_step) + 8192) >>> 14;
      end
      ang_r = cordic_angle(acc[0], acc[2]);
      ang_p = cordic_angle(acc[1], acc[2]);
      tau = (m_weight > 32768) ? 32768 : m_weight;
      v = tau * (m_roll - inc[1]) + (32768 - tau) * ang_r;
      m_roll = sat_to((v + 16384) >>> 15, -longint'(2147483647) - 1, longint'(2147483647));
      v = tau * (m_pitch + inc[0]) + (32768 - tau) * ang_p;
      m_pitch = sat_to((v + 16384) >>> 15, -longint'(2147483647) - 1, longint'(2147483647));
      m_yaw = m_yaw + inc[2][31:0];
      r.roll = m_roll[31:0];
      r.pitch = m_pitch[31:0];
      r.yaw = m_yaw;
      r.ax = acc[0][18:0];
      r.ay = acc[1][18:0];
      r.az = acc[2][18:0];
      r.rx = rate[0][18:0];
      r.ry = rate[1][18:0];
      r.rz = rate[2][18:0];
      return r;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         imu_ca_pkg::REG_ACCEL_RANGE: m_accel_rng = val[1:0];
         imu_ca_pkg::REG_GYRO_RANGE:  m_gyro_rng = val[1:0];
         imu_ca_pkg::REG_BLEND:       m_weight = val[15:0];
         imu_ca_pkg::REG_STEP:        m_step = val[23:0];
         imu_ca_pkg::REG_OFF_GX:      m_off[0] = longint'(signed'(val[19:0]));
         imu_ca_pkg::REG_OFF_GY:      m_off[1] = longint'(signed'(val[19:0]));
         imu_ca_pkg::REG_OFF_GZ:      m_off[2] = longint'(signed'(val[19:0]));
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic write_all(input int unsigned ar, gr, w, st, input int ox, oy, oz);
      csr_write(imu_ca_pkg::REG_ACCEL_RANGE, ar);
      csr_write(imu_ca_pkg::REG_GYRO_RANGE, gr);
      csr_write(imu_ca_pkg::REG_BLEND, w);
      csr_write(imu_ca_pkg::REG_STEP, st);
      csr_write(imu_ca_pkg::REG_OFF_GX, ox);
      csr_write(imu_ca_pkg::REG_OFF_GY, oy);
      csr_write(imu_ca_pkg::REG_OFF_GZ, oz);
   endtask

   // called at a falling edge; withdraws the offer and waits for every result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input logic signed [15:0] s[6]);
      int gap;
      attitude_type e;
      gap = $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_raw_ax <= s[0]; req_raw_ay <= s[1]; req_raw_az <= s[2];
      req_raw_gx <= s[3]; req_raw_gy <= s[4]; req_raw_gz <= s[5];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      e = advance_attitude(s);
      if (typed_next) e = typed_val;
      typed_next = 1'b0;
      expected_q.push_back(e);
      @(negedge clock);
   endtask

   function automatic void random_sample(output logic signed [15:0] s[6]);
      if ($urandom_range(0, 9) < 7) begin
         for (int k = 0; k < 6; k++) s[k] = 16'($urandom);
      end else begin
         for (int k = 0; k < 6; k++) s[k] = 16'($urandom_range(0, 8191) - 4096);
         s[2] = s[2] + 16'sd8192;
      end
   endfunction

   function automatic void check_field(input string nm, input longint exp_v, act_v);
      if (exp_v != act_v) begin
         $display("%0t %s expected %0d actual %0d", $time, nm, exp_v, act_v);
         errors++;
      end
   endfunction

   // result side
   initial begin
      int n;
      attitude_type e;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         n = hold_long ? 400 : $urandom_range(0, 11);
         hold_long = 1'b0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (expected_q.size() == 0) begin
            $display("%0t unexpected beat roll %0d", $time, rsp_roll_deg);
            errors++;
         end else begin
            e = expected_q.pop_front();
            check_field("roll", e.roll, rsp_roll_deg);
            check_field("pitch", e.pitch, rsp_pitch_deg);
            check_field("yaw", e.yaw, rsp_yaw_deg);
            check_field("accel_x", e.ax, rsp_accel_x_g);
            check_field("accel_y", e.ay, rsp_accel_y_g);
            check_field("accel_z", e.az, rsp_accel_z_g);
            check_field("rate_x", e.rx, rsp_rate_x_dps);
            check_field("rate_y", e.ry, rsp_rate_y_dps);
            check_field("rate_z", e.rz, rsp_rate_z_dps);
         end
         @(negedge clock);
      end
   end

   initial begin
      sample_row_type tbl[$];
      sample_row_type row;
      logic signed [15:0] s[6];
      int unsigned w;
      errors = 0;
      hold_long = 1'b0;
      typed_next = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_raw_ax, req_raw_ay, req_raw_az, req_raw_gx, req_raw_gy, req_raw_gz} = '0;
      {psel, penable, pwrite} = 3'b000;
      paddr = '0;
      pwdata = '0;
      m_accel_rng = 1; m_gyro_rng = 1; m_weight = 32113; m_step = 16777;
      m_off = '{0, 0, 0};
      m_roll = 0; m_pitch = 0; m_yaw = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ax, ay, az, gx, gy, gz
      tbl = '{'{'{0, 0, 0, 0, 0, 0}, 1},
              '{'{32767, 32767, 32767, 32767, 32767, 32767}, 0},
              '{'{-32768, -32768, -32768, -32768, -32768, -32768}, 0},
              '{'{0, 0, 16384, 0, 0, 0}, 0},
              '{'{100, -100, 0, 1, -1, 0}, 0},
              '{'{0, 0, -16384, 5, 5, 5}, 0},
              '{'{4000, -4000, -16000, -200, 300, 131}, 0},
              '{'{-4000, 4000, -16000, 200, -300, -131}, 0},
              '{'{32767, -32768, 1, 32767, -32768, 1}, 0},
              '{'{-1, -1, -1, -1, -1, -1}, 0},
              '{'{1, 1, 1, 1, 1, 1}, 0},
              '{'{0, 5000, 0, -32768, 32767, 0}, 0}};
      foreach (tbl[i]) begin
         row = tbl[i];
         typed_next = row.typed;
         typed_val = '0;
         send_sample(row.s);
      end
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_all(0, 0, 0, 0, 524287, -524288, 0);
            1: write_all(3, 3, 32768, 16777215, -524288, 524287, 524287);
            2: write_all(2, 2, 65535, 16777, 0, 0, -524288);
            3: write_all(1, 1, 32113, 16777, 160, -320, 48);
            default: begin
               w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(30000, 32768);
               write_all($urandom_range(0, 3), $urandom_range(0, 3), w,
                         $urandom_range(0, 16777215),
                         $urandom_range(0, 1048575) - 524288,
                         $urandom_range(0, 1048575) - 524288,
                         $urandom_range(0, 1048575) - 524288);
            end
         endcase
         for (int i = 0; i < 80; i++) begin
            if (p == 2 && i == 10) hold_long = 1'b1;
            if (p == 4 && i == 40) wait_drained();
            random_sample(s);
            send_sample(s);
         end
         wait_drained();
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("imu_complementary_attitude: match");
      end else begin
         $display("imu_complementary_attitude: mismatch");
      end
      $finish;
   end

endmodule
